FILE: rtl/b64_pkg.sv
// Shared types, character constants and alphabet helpers for the Base64 codec.
`timescale 1ns / 1ps
package b64_pkg;

  localparam int GROUP_W     = 18;  // widest partial group: three sixtets
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHR_PAD   = 8'h3d;  // '='
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_NL    = 8'h0a;
  localparam logic [7:0] CHR_NUL   = 8'h00;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic REG_MODE_IDX = 1'b0;

  // One request for the back end: up to four results, first in bytes[0].
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;  // index of the final result in this request
    logic            last;      // final result closes the message
    logic            bare;      // single result without data
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  function automatic logic [5:0] dec_sixtet(input logic [7:0] c);
    logic [5:0] s;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      s = 6'd62;
    end else if (c == 8'h2f) begin
      s = 6'd63;
    end else begin
      s = 6'd0;
    end
    return s;
  endfunction

endpackage

FILE: rtl/b64_if.sv
// Valid/ready stream interfaces for the codec input and result channels.
`timescale 1ns / 1ps
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  output ready);
endinterface

FILE: rtl/b64_front.sv
// Front end: accept items, track the group state and build result requests.
`timescale 1ns / 1ps
module b64_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic             clear_i,
  input  logic             full_i,
  b64_in_if.sink           in_i,
  output logic             push_o,
  output b64_pkg::job_t    job_o
);
  import b64_pkg::*;

  logic [GROUP_W-1:0] group_q, group_d;
  logic [1:0]         count_q, count_d;
  logic               stopped_q, stopped_d;
  logic               accept;
  logic               job_valid;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept && job_valid;

  always_comb begin
    logic [7:0]         c;
    logic [23:0]        nb;
    logic [11:0]        v2;
    logic [17:0]        v3;
    logic [GROUP_W-1:0] g1;
    logic [1:0]         c1;
    logic [1:0]         n;
    logic               any;
    logic               is_term;
    logic               is_ws;

    c         = in_i.data_byte;
    group_d   = group_q;
    count_d   = count_q;
    stopped_d = stopped_q;
    job_o     = '0;
    job_valid = 1'b0;
    nb        = '0;
    v2        = '0;
    v3        = '0;
    g1        = group_q;
    c1        = count_q;
    n         = 2'd0;
    any       = 1'b0;
    is_term   = (c == CHR_PAD) || (c == CHR_NUL);
    is_ws     = (c == CHR_SPACE) || (c == CHR_NL);

    if (mode_i == MODE_ENC) begin
      nb        = {group_q[15:0], c};
      stopped_d = 1'b0;
      if (count_q == 2'd2) begin
        job_o.bytes[0] = enc_char(nb[23:18]);
        job_o.bytes[1] = enc_char(nb[17:12]);
        job_o.bytes[2] = enc_char(nb[11:6]);
        job_o.bytes[3] = enc_char(nb[5:0]);
        job_o.last_idx = 2'd3;
        job_o.last     = in_i.last;
        job_valid      = 1'b1;
        group_d        = '0;
        count_d        = 2'd0;
      end else if (in_i.last) begin
        if (count_q == 2'd0) begin
          v2 = {c, 4'b0000};
          job_o.bytes[0] = enc_char(v2[11:6]);
          job_o.bytes[1] = enc_char(v2[5:0]);
          job_o.bytes[2] = CHR_PAD;
        end else begin
          v3 = {group_q[7:0], c, 2'b00};
          job_o.bytes[0] = enc_char(v3[17:12]);
          job_o.bytes[1] = enc_char(v3[11:6]);
          job_o.bytes[2] = enc_char(v3[5:0]);
        end
        job_o.bytes[3] = CHR_PAD;
        job_o.last_idx = 2'd3;
        job_o.last     = 1'b1;
        job_valid      = 1'b1;
        group_d        = '0;
        count_d        = 2'd0;
      end else begin
        group_d = nb[GROUP_W-1:0];
        count_d = count_q + 2'd1;
      end
    end else begin
      // Pass one: the character itself.
      if (!stopped_q) begin
        if (is_term) begin
          if (count_q == 2'd2) begin
            job_o.bytes[0] = group_q[11:4];
            n   = 2'd0;
            any = 1'b1;
          end else if (count_q == 2'd3) begin
            job_o.bytes[0] = group_q[17:10];
            job_o.bytes[1] = group_q[9:2];
            n   = 2'd1;
            any = 1'b1;
          end
          g1        = '0;
          c1        = 2'd0;
          stopped_d = 1'b1;
        end else if (!is_ws) begin
          nb = {group_q, dec_sixtet(c)};
          if (count_q == 2'd3) begin
            job_o.bytes[0] = nb[23:16];
            job_o.bytes[1] = nb[15:8];
            job_o.bytes[2] = nb[7:0];
            n   = 2'd2;
            any = 1'b1;
            g1  = '0;
            c1  = 2'd0;
          end else begin
            g1 = nb[GROUP_W-1:0];
            c1 = count_q + 2'd1;
          end
        end
      end
      group_d = g1;
      count_d = c1;
      // Pass two: close the message, flushing what the first pass left.
      if (in_i.last) begin
        if (!any) begin
          if (c1 == 2'd2) begin
            job_o.bytes[0] = g1[11:4];
            n   = 2'd0;
            any = 1'b1;
          end else if (c1 == 2'd3) begin
            job_o.bytes[0] = g1[17:10];
            job_o.bytes[1] = g1[9:2];
            n   = 2'd1;
            any = 1'b1;
          end
        end
        job_o.bare = !any;
        job_o.last = 1'b1;
        group_d    = '0;
        count_d    = 2'd0;
        stopped_d  = 1'b0;
      end
      job_o.last_idx = n;
      job_valid      = any || in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q   <= '0;
      count_q   <= 2'd0;
      stopped_q <= 1'b0;
    end else if (clear_i) begin
      group_q   <= '0;
      count_q   <= 2'd0;
      stopped_q <= 1'b0;
    end else if (accept) begin
      group_q   <= group_d;
      count_q   <= count_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

FILE: rtl/b64_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module b64_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64_pkg::job_t   job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            head_valid_o,
  output b64_pkg::job_t   head_o
);
  import b64_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/b64_back.sv
// Back end: walk each request and drive results through an output register.
`timescale 1ns / 1ps
module b64_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  b64_pkg::job_t   head_i,
  output logic            pop_o,
  b64_out_if.source       out_o
);
  import b64_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       bvalid_q;
  logic       last_q;
  logic       load;
  logic       at_end;

  assign load   = head_valid_i && (!valid_q || out_o.ready);
  assign at_end = (idx_q == head_i.last_idx);
  assign pop_o  = load && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = at_end ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= head_i.bytes[idx_q];
      bvalid_q <= !head_i.bare;
      last_q   <= head_i.last && at_end;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.byte_valid = bvalid_q;
  assign out_o.out_last   = last_q;

endmodule

FILE: rtl/base64_stream_codec_unit.sv
// Top level of the streaming Base64 encoder/decoder with its APB mode register.
// Results of an accepted item pass through the request queue, then the output register to out_o.
// Throughput: one item per cycle while the queue has room, one result per cycle out while the
//   sink takes them; encoding yields four results per three bytes.
// Reset: rst_ni (async, active low) clears mode to encode, the group state, the queue
//   and the output valid flag; no memory needs a clearing pass.
`timescale 1ns / 1ps
module base64_stream_codec_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64_in_if.sink      in_i,
  b64_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import b64_pkg::*;

  logic mode_q, mode_d;
  logic mode_wr;
  logic push;
  logic pop;
  logic full;
  logic head_valid;
  job_t job;
  job_t head;

  // APB: zero wait states; the mode register answers wherever paddr[2] is
  // zero, other addresses read as zero and drop writes.
  assign pready  = 1'b1;
  assign mode_wr = psel && penable && pwrite && (paddr[2] == REG_MODE_IDX);
  assign mode_d  = mode_wr ? pwdata[0] : mode_q;
  assign prdata  = (paddr[2] == REG_MODE_IDX) ? {31'b0, mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENC;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Front end: classify each item and build a request of up to four results.
  // A mode write also drops any unfinished group.
  b64_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .clear_i (mode_wr),
    .full_i  (full),
    .in_i    (in_i),
    .push_o  (push),
    .job_o   (job)
  );

  // Queue: decouples input acceptance from result delivery.
  b64_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back end: advance one result per cycle while the sink takes them.
  b64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

FILE: rtl/b64_checker.sv
// Port-level assertions for the Base64 codec, bound to the top level.
`timescale 1ns / 1ps
module b64_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       out_last,
  input logic [2:0] paddr,
  input logic [31:0] prdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(byte_valid) && $stable(out_last))
    else $error("stalled result changed");

  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !byte_valid |-> out_last)
    else $error("end marker without out_last");

  a_bare_only_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !byte_valid && !paddr[2] |-> prdata[0])
    else $error("end marker in encode mode");

endmodule

bind base64_stream_codec_unit b64_checker u_b64_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_byte   (out_o.out_byte),
  .byte_valid (out_o.byte_valid),
  .out_last   (out_o.out_last),
  .paddr      (paddr),
  .prdata     (prdata)
);
